// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the access unit gate RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define VAUG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vaug: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define VAUG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vaug: next-cycle check failed");

`endif

// ----- rtl/vaug_pkg.sv -----
// Types, constants and hash helpers shared by the access unit gate modules.
package vaug_pkg;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_LOSS = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    VERD_ACCEPT = 2'd0,
    VERD_DROP   = 2'd1,
    VERD_CHANGE = 2'd2
  } verdict_e;

  // Codec as it arrives on the input.
  localparam logic [1:0] CODEC_IN_H265 = 2'd1;

  // Codec as it is stored: zero means none seen yet.
  localparam logic [1:0] SC_NONE = 2'd0;
  localparam logic [1:0] SC_H265 = 2'd2;

  // NAL unit type codes.
  localparam logic [5:0] H264_IDR     = 6'd5;
  localparam logic [5:0] H264_SPS     = 6'd7;
  localparam logic [5:0] H264_PPS     = 6'd8;
  localparam logic [5:0] H265_IDR_W   = 6'd19;
  localparam logic [5:0] H265_IDR_N   = 6'd20;
  localparam logic [5:0] H265_CRA     = 6'd21;
  localparam logic [5:0] H265_VCL_MAX = 6'd31;
  localparam logic [5:0] H265_VPS     = 6'd32;
  localparam logic [5:0] H265_SPS     = 6'd33;
  localparam logic [5:0] H265_PPS     = 6'd34;

  // Parameter set slots.
  localparam logic [1:0] PRM_VPS = 2'd0;
  localparam logic [1:0] PRM_SPS = 2'd1;
  localparam logic [1:0] PRM_PPS = 2'd2;

  // FNV-1a constants and their powers, all modulo 2**32.
  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [31:0] FNV_P2    = FNV_PRIME * FNV_PRIME;
  localparam logic [31:0] FNV_P3    = FNV_P2 * FNV_PRIME;
  localparam logic [31:0] FNV_P4    = FNV_P3 * FNV_PRIME;
  localparam logic [31:0] FNV_BP1   = FNV_BASIS * FNV_PRIME;
  localparam logic [31:0] FNV_BP2   = FNV_BASIS * FNV_P2;
  localparam logic [31:0] FNV_BP3   = FNV_BASIS * FNV_P3;

  // One queued operation: the work the back end does for one accepted beat.
  // The hash is kept one multiply behind: hash = u * prime.
  typedef struct packed {
    logic       loss;     // loss event
    logic       clr;      // codec switch clears the gate first
    logic       nal_open; // start code: hash restarts after this beat
    logic [2:0] cnt;      // bytes committed to the hash (zeros, then val)
    logic [7:0] val;      // value of the last committed byte
    logic       fin;      // a parameter set NAL ends and is stored
    logic       fin_pre;  // it ends before this beat's commits
    logic [1:0] fin_idx;  // parameter set slot
    logic       decide;   // last byte of the unit: give a verdict
    logic       err;
    logic       vcl;
    logic       idr;
    logic [2:0] prm;
    logic       disc;
  } op_t;

  // prime ** n for n up to four.
  function automatic logic [31:0] fnv_pow(input logic [2:0] n);
    logic [31:0] r;
    case (n)
      3'd1:    r = FNV_PRIME;
      3'd2:    r = FNV_P2;
      3'd3:    r = FNV_P3;
      3'd4:    r = FNV_P4;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  // basis * prime ** (n - 1) for n from one to four.
  function automatic logic [31:0] fnv_basis_pow(input logic [2:0] n);
    logic [31:0] r;
    case (n)
      3'd2:    r = FNV_BP1;
      3'd3:    r = FNV_BP2;
      3'd4:    r = FNV_BP3;
      default: r = FNV_BASIS;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/vaug_front.sv -----
// Front end: start code search, NAL header classification and unit flags.
module vaug_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            command_i,
  input  logic [7:0]      data_byte_i,
  input  logic [1:0]      codec_kind_i,
  input  logic            discontinuity_i,
  input  logic            last_byte_i,
  output vaug_pkg::op_t   op_o
);
  import vaug_pkg::*;

  typedef struct packed {
    logic       err;
    logic       vcl;
    logic       idr;
    logic       store;
    logic [1:0] idx;
  } fin_t;

  // Classifies a NAL unit that has just ended.
  function automatic fin_t nal_finish(input logic [5:0] k, input logic [1:0] len,
                                      input logic h5);
    fin_t r;
    logic is_idr;
    r = '0;
    is_idr = h5 ? (k == H265_IDR_W || k == H265_IDR_N || k == H265_CRA) : (k == H264_IDR);
    if (len == 2'd0) begin
      r.err = 1'b1;
    end else if (is_idr) begin
      if (len < (h5 ? 2'd3 : 2'd2)) begin
        r.err = 1'b1;
      end else begin
        r.vcl = 1'b1;
        r.idr = 1'b1;
      end
    end else if (h5 ? (k <= H265_VCL_MAX) : (k >= 6'd1 && k <= H264_IDR)) begin
      r.vcl = 1'b1;
    end else if (h5 && k == H265_VPS) begin
      r.store = 1'b1;
      r.idx   = PRM_VPS;
    end else if (h5 ? (k == H265_SPS) : (k == H264_SPS)) begin
      r.store = 1'b1;
      r.idx   = PRM_SPS;
    end else if (h5 ? (k == H265_PPS) : (k == H264_PPS)) begin
      r.store = 1'b1;
      r.idx   = PRM_PPS;
    end
    return r;
  endfunction

  logic       in_unit_q, in_unit_d;
  logic [1:0] codec_q, codec_d;
  logic       started_q, started_d;
  logic       error_q, error_d;
  logic       vcl_q, vcl_d;
  logic       idr_q, idr_d;
  logic [2:0] prm_q, prm_d;
  logic [1:0] zrun_q, zrun_d;
  logic [1:0] nlen_q, nlen_d;
  logic [5:0] nkind_q, nkind_d;

  // Walk one beat through the parser and build its back end operation.
  always_comb begin
    op_t        op;
    fin_t       fr;
    logic       h5;
    logic       sc;
    logic       hb;
    logic [2:0] nz;
    logic [2:0] nc;
    logic [3:0] lsum;
    op        = '0;
    fr        = '0;
    h5        = 1'b0;
    sc        = 1'b0;
    hb        = 1'b0;
    nz        = '0;
    nc        = '0;
    lsum      = '0;
    in_unit_d = in_unit_q;
    codec_d   = codec_q;
    started_d = started_q;
    error_d   = error_q;
    vcl_d     = vcl_q;
    idr_d     = idr_q;
    prm_d     = prm_q;
    zrun_d    = zrun_q;
    nlen_d    = nlen_q;
    nkind_d   = nkind_q;
    if (command_i == CMD_LOSS) begin
      op.loss = 1'b1;
    end else begin
      // First byte of a unit: clear the unit state and sample the codec.
      if (!in_unit_q) begin
        started_d = 1'b0;
        error_d   = 1'b0;
        vcl_d     = 1'b0;
        idr_d     = 1'b0;
        prm_d     = '0;
        zrun_d    = '0;
        nlen_d    = '0;
        nkind_d   = '0;
        if (codec_kind_i > CODEC_IN_H265) begin
          error_d = 1'b1;
        end else begin
          op.clr  = (codec_q != SC_NONE) && (codec_q != codec_kind_i + 2'd1);
          codec_d = codec_kind_i + 2'd1;
        end
      end
      h5 = (codec_d == SC_H265);

      // Zero run and start code detection.
      if (!error_d) begin
        if (data_byte_i == 8'h00) begin
          if (zrun_d != 2'd3) begin
            zrun_d = zrun_d + 2'd1;
          end else begin
            nz = 3'd1;
          end
        end else if (data_byte_i == 8'h01 && zrun_d >= 2'd2) begin
          sc = 1'b1;
        end else begin
          nz     = {1'b0, zrun_d};
          hb     = 1'b1;
          zrun_d = '0;
        end
      end

      // A start code ends the NAL in progress and opens a new one.
      if (sc) begin
        if (started_d && !error_d) begin
          fr      = nal_finish(nkind_d, nlen_d, h5);
          error_d = error_d | fr.err;
          vcl_d   = vcl_d | fr.vcl;
          idr_d   = idr_d | fr.idr;
          if (fr.store) begin
            op.fin          = 1'b1;
            op.fin_pre      = 1'b1;
            op.fin_idx      = fr.idx;
            prm_d[fr.idx]   = 1'b1;
          end
        end
        started_d   = 1'b1;
        nlen_d      = '0;
        nkind_d     = '0;
        zrun_d      = '0;
        op.nal_open = 1'b1;
      end

      // Bytes only count inside a NAL of a healthy unit.
      if (!(started_d && !error_d)) begin
        nz = '0;
        hb = 1'b0;
      end

      // The last byte flushes pending zeros, or finds no start code at all.
      if (last_byte_i && !error_d) begin
        if (!started_d) begin
          error_d = 1'b1;
        end else begin
          nz = nz + {1'b0, zrun_d};
        end
      end

      // Length and type of the current NAL follow the committed bytes.
      nc = nz + {2'b00, hb};
      if (nc != 3'd0) begin
        if (nlen_d == 2'd0) begin
          if (nz != 3'd0) begin
            nkind_d = '0;
          end else begin
            nkind_d = h5 ? data_byte_i[6:1] : {1'b0, data_byte_i[4:0]};
          end
        end
        lsum   = {2'b00, nlen_d} + {1'b0, nc};
        nlen_d = (lsum >= 4'd3) ? 2'd3 : lsum[1:0];
      end

      // End of the unit closes the last NAL.
      if (last_byte_i && !error_d) begin
        fr      = nal_finish(nkind_d, nlen_d, h5);
        error_d = error_d | fr.err;
        vcl_d   = vcl_d | fr.vcl;
        idr_d   = idr_d | fr.idr;
        if (fr.store) begin
          op.fin        = 1'b1;
          op.fin_idx    = fr.idx;
          prm_d[fr.idx] = 1'b1;
        end
      end

      op.cnt    = nc;
      op.val    = hb ? data_byte_i : 8'h00;
      op.decide = last_byte_i;
      op.err    = error_d;
      op.vcl    = vcl_d;
      op.idr    = idr_d;
      op.prm    = prm_d;
      op.disc   = discontinuity_i;
      if (last_byte_i) begin
        in_unit_d = 1'b0;
        zrun_d    = '0;
      end else begin
        in_unit_d = 1'b1;
      end
    end
    op_o = op;
  end

  // Parser state advances on each accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_unit_q <= 1'b0;
      codec_q   <= SC_NONE;
      started_q <= 1'b0;
      error_q   <= 1'b0;
      vcl_q     <= 1'b0;
      idr_q     <= 1'b0;
      prm_q     <= '0;
      zrun_q    <= '0;
      nlen_q    <= '0;
      nkind_q   <= '0;
    end else if (accept_i) begin
      in_unit_q <= in_unit_d;
      codec_q   <= codec_d;
      started_q <= started_d;
      error_q   <= error_d;
      vcl_q     <= vcl_d;
      idr_q     <= idr_d;
      prm_q     <= prm_d;
      zrun_q    <= zrun_d;
      nlen_q    <= nlen_d;
      nkind_q   <= nkind_d;
    end
  end

endmodule

// ----- rtl/vaug_fifo.sv -----
// Operation queue between the front end and the back end.
module vaug_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vaug_pkg::op_t wdata_i,
  input  logic          pop_i,
  output vaug_pkg::op_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import vaug_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  op_t           mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule

// ----- rtl/vaug_back.sv -----
// Back end: parameter set hashing, gate flags and the verdict register.
module vaug_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  vaug_pkg::op_t q_op_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    verdict_o
);
  import vaug_pkg::*;

  logic        en;
  logic [31:0] u_q, u_d;
  logic        empty_q, empty_d;
  logic [31:0] prod;
  logic [31:0] hnew;
  logic        b1_valid_q;
  op_t         b1_op_q;
  logic [31:0] b1_hash_q;
  logic        wait_q, wait_d;
  logic        chg_q, chg_d;
  logic        init_q, init_d;
  logic [2:0]  seen_q, seen_d;
  logic [31:0] ph_q [3];
  logic [31:0] ph_d [3];
  logic [31:0] uph_q [3];
  logic [31:0] uph_d [3];
  logic        out_valid_q, out_valid_d;
  verdict_e    verdict_q, verdict_d;

  // The whole back end moves unless a verdict waits on a stalled output.
  assign en      = !(out_valid_q && out_stall_i);
  assign q_pop_o = en && !q_empty_i;

  // Hash stage: fold the committed bytes in with one constant multiply.
  assign prod = u_q * fnv_pow(q_op_i.cnt);
  always_comb begin
    if (q_op_i.cnt == 3'd0) begin
      hnew = u_q;
    end else begin
      hnew = (empty_q ? fnv_basis_pow(q_op_i.cnt) : prod) ^ {24'h000000, q_op_i.val};
    end
    u_d     = u_q;
    empty_d = empty_q;
    if (q_op_i.nal_open) begin
      empty_d = 1'b1;
    end else if (q_op_i.cnt != 3'd0) begin
      u_d     = hnew;
      empty_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_q    <= 1'b1;
      b1_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q <= q_pop_o;
      if (q_pop_o) begin
        empty_q <= empty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      u_q       <= u_d;
      b1_op_q   <= q_op_i;
      b1_hash_q <= q_op_i.fin_pre ? u_q : hnew;
    end
  end

  // Gate stage: store parameter hashes, update the flags, give the verdict.
  always_comb begin
    logic [31:0] uph_eff [3];
    logic        fc;
    wait_d      = wait_q;
    chg_d       = chg_q;
    init_d      = init_q;
    seen_d      = seen_q;
    ph_d        = ph_q;
    uph_d       = uph_q;
    out_valid_d = out_valid_q;
    verdict_d   = verdict_q;
    fc          = 1'b0;
    for (int i = 0; i < 3; i++) begin
      uph_eff[i] = (b1_op_q.fin && b1_op_q.fin_idx == 2'(i)) ? b1_hash_q : uph_q[i];
    end
    if (en) begin
      out_valid_d = 1'b0;
      if (b1_valid_q) begin
        uph_d = uph_eff;
        if (b1_op_q.clr) begin
          wait_d = 1'b0;
          chg_d  = 1'b0;
          init_d = 1'b0;
          seen_d = '0;
        end
        if (b1_op_q.loss) begin
          wait_d = 1'b1;
          chg_d  = 1'b1;
        end
        if (b1_op_q.decide) begin
          out_valid_d = 1'b1;
          if (b1_op_q.err) begin
            wait_d    = 1'b1;
            verdict_d = VERD_DROP;
          end else begin
            if (b1_op_q.disc) begin
              wait_d = 1'b1;
            end
            if (!b1_op_q.vcl && b1_op_q.prm == 3'b000) begin
              wait_d    = 1'b1;
              verdict_d = VERD_DROP;
            end else begin
              // A changed parameter set against one seen before is a format change.
              for (int i = 0; i < 3; i++) begin
                if (init_d && b1_op_q.prm[i] && seen_d[i] && uph_eff[i] != ph_q[i]) begin
                  fc = 1'b1;
                end
                if (b1_op_q.prm[i]) begin
                  ph_d[i] = uph_eff[i];
                end
              end
              seen_d = seen_d | b1_op_q.prm;
              if (fc) begin
                wait_d    = !b1_op_q.idr;
                chg_d     = !b1_op_q.idr;
                if (b1_op_q.idr) begin
                  init_d = 1'b1;
                end
                verdict_d = VERD_CHANGE;
              end else if (b1_op_q.idr) begin
                wait_d = 1'b0;
                init_d = 1'b1;
                if (chg_d) begin
                  chg_d     = 1'b0;
                  verdict_d = VERD_CHANGE;
                end else begin
                  verdict_d = VERD_ACCEPT;
                end
              end else if (wait_d || (b1_op_q.vcl && !init_d)) begin
                verdict_d = VERD_DROP;
              end else begin
                verdict_d = VERD_ACCEPT;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q      <= 1'b0;
      chg_q       <= 1'b0;
      init_q      <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wait_q      <= wait_d;
      chg_q       <= chg_d;
      init_q      <= init_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q      <= ph_d;
    uph_q     <= uph_d;
    verdict_q <= verdict_d;
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ----- rtl/video_access_unit_gate.sv -----
// Top level of the Annex B access unit gate.
//
//   channel | direction | beat                                   | handshake
//   --------+-----------+----------------------------------------+---------------------
//   in      | input     | command, data_byte, codec_kind, disc,  | in_valid_i/in_stall_o
//           |           | last_byte                              |
//   out     | output    | verdict                                | out_valid_o/out_stall_i
//
// One beat is taken every cycle while in_stall_o is low; the front end parses it in the accept cycle.
// The operation queue holds QueueDepth beats, so in_stall_o rises only when it is full.
// The back end registers the hash multiply result and then the gate flags and verdict,
// so a verdict leaves once its last byte has left the queue and passed through both.
// A verdict held on a stalled output freezes the back end; reset empties everything.
`include "assert_macros.svh"

module video_access_unit_gate #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  input  logic [1:0] codec_kind_i,
  input  logic       discontinuity_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);
  import vaug_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  op_t  q_wdata;
  op_t  q_rdata;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  // Parser.
  vaug_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (q_push),
    .command_i       (command_i),
    .data_byte_i     (data_byte_i),
    .codec_kind_i    (codec_kind_i),
    .discontinuity_i (discontinuity_i),
    .last_byte_i     (last_byte_i),
    .op_o            (q_wdata)
  );

  // Decoupling queue.
  vaug_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Hash and gate logic.
  vaug_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_op_i      (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o)
  );

  // The queue never takes a beat while it is full.
  `VAUG_ASSERT_IMPLY(a_no_push_full, q_full, !q_push)
  // A last byte always asks the back end for a verdict.
  `VAUG_ASSERT_IMPLY(a_last_decides, q_push && !q_wdata.loss && last_byte_i, q_wdata.decide)
  // A loss event never produces a verdict.
  `VAUG_ASSERT_IMPLY(a_loss_silent, q_push && q_wdata.loss, !q_wdata.decide)
  // Only the three defined verdicts leave the block.
  `VAUG_ASSERT_IMPLY(a_verdict_code, out_valid_o, verdict_o <= VERD_CHANGE)

endmodule
